// ----- hdl/pbid_pkg.sv -----
// Shared types, codes and constants for the palette bitstream image decoder.
package pbid_pkg;

  localparam int PIX_W   = 20;
  localparam int CFG_W   = 20;
  localparam int QDEPTH  = 2;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  localparam logic [1:0] REG_MODE         = 2'd0;
  localparam logic [1:0] REG_PALETTE_BITS = 2'd1;
  localparam logic [1:0] REG_FILL_COLOR   = 2'd2;
  localparam logic [1:0] REG_TOTAL_PIXELS = 2'd3;

  localparam logic [1:0] MODE_TABLE = 2'd0;
  localparam logic [1:0] MODE_RUNS  = 2'd1;
  localparam logic [1:0] MODE_SIGN  = 2'd2;

  typedef enum logic [1:0] {
    K_START,
    K_BYTE,
    K_FILL
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ONE,
    PH_DELTA,
    PH_LITERAL,
    PH_RUN,
    PH_SIGN
  } phase_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
  } queue_head_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [3:0]       palette_bits;
    logic [7:0]       fill_color;
    logic [PIX_W-1:0] total_pixels;
  } cfg_t;

  function automatic logic [7:0] delta_of(input logic [2:0] v);
    logic [7:0] d;
    case (v)
      3'd0:    d = 8'd252;
      3'd1:    d = 8'd253;
      3'd2:    d = 8'd254;
      3'd3:    d = 8'd255;
      3'd4:    d = 8'd1;
      3'd5:    d = 8'd2;
      3'd6:    d = 8'd3;
      default: d = 8'd4;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/pbid_if.sv -----
// Valid/ready channel interfaces for input items and output runs.
interface pbid_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface pbid_run_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                pixel_color;
  logic [pbid_pkg::PIX_W-1:0] repeat_count;
  logic                      last;

  modport source (output valid, pixel_color, repeat_count, last, input ready);
  modport sink (input valid, pixel_color, repeat_count, last, output ready);
endinterface

// ----- hdl/palette_bitstream_image_decoder_unit.sv -----
// Top level of the palette bitstream image decoder: config registers, front and back.
//
// Each item beat is queued by the front end (two entries) and carried out by the
// back end. A start or empty-image item gives one run. The bit-serial parser takes a
// payload byte one bit at a time; each bit may finish a code and load the output
// register with one run, so a byte gives up to eight runs. Once the image total is
// reached, further bytes are dropped until the next start. A stalled output register
// holds the parser, and the queue keeps taking items until it is full. Unknown
// commands are taken and dropped.
module palette_bitstream_image_decoder_unit (
  input  logic                       clk,
  input  logic                       rst,
  pbid_item_if.sink                  items,
  pbid_run_if.source                 runs,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [pbid_pkg::CFG_W-1:0] cfg_data
);

  pbid_pkg::cfg_t        cfg;
  pbid_pkg::queue_head_t head;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= pbid_pkg::MODE_TABLE;
      cfg.palette_bits <= 4'd8;
      cfg.fill_color   <= 8'd0;
      cfg.total_pixels <= pbid_pkg::PIX_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbid_pkg::REG_MODE:         cfg.mode         <= cfg_data[1:0];
        pbid_pkg::REG_PALETTE_BITS: cfg.palette_bits <= cfg_data[3:0];
        pbid_pkg::REG_FILL_COLOR:   cfg.fill_color   <= cfg_data[7:0];
        pbid_pkg::REG_TOTAL_PIXELS: cfg.total_pixels <= cfg_data[pbid_pkg::PIX_W-1:0];
        default:                    cfg.mode         <= cfg.mode;
      endcase
    end
  end

  pbid_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .head  (head),
    .pop   (pop)
  );

  pbid_back u_back (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .head (head),
    .pop  (pop),
    .runs (runs)
  );

endmodule

// ----- hdl/pbid_front.sv -----
// Front end: accepts item beats, classifies commands and queues them.
module pbid_front (
  input  logic                  clk,
  input  logic                  rst,
  pbid_item_if.sink             items,
  output pbid_pkg::queue_head_t head,
  input  logic                  pop
);

  localparam int PW = $clog2(pbid_pkg::QDEPTH);

  pbid_pkg::kind_t  q_kind [pbid_pkg::QDEPTH];
  logic [7:0]       q_data [pbid_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             take;
  logic             push;
  logic             known;
  pbid_pkg::kind_t  kind;

  always_comb begin
    known = 1'b1;
    kind  = pbid_pkg::K_BYTE;
    case (items.cmd)
      pbid_pkg::CMD_START: kind = pbid_pkg::K_START;
      pbid_pkg::CMD_BYTE:  kind = pbid_pkg::K_BYTE;
      pbid_pkg::CMD_FILL:  kind = pbid_pkg::K_FILL;
      default:             known = 1'b0;
    endcase
  end

  assign items.ready = (count != (PW+1)'(pbid_pkg::QDEPTH));
  assign take        = items.valid && items.ready;
  assign push        = take && known;

  assign head.valid = (count != '0);
  assign head.kind  = q_kind[rd_ptr];
  assign head.data  = q_data[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_kind[wr_ptr] <= kind;
      q_data[wr_ptr] <= items.data_byte;
    end
  end

endmodule

// ----- hdl/pbid_back.sv -----
// Back end: bit-serial code parser, run clamping and output register.
module pbid_back (
  input  logic                  clk,
  input  logic                  rst,
  input  pbid_pkg::cfg_t        cfg,
  input  pbid_pkg::queue_head_t head,
  output logic                  pop,
  pbid_run_if.source            runs
);

  localparam int PW = pbid_pkg::PIX_W;

  // parser state
  pbid_pkg::phase_t phase;
  pbid_pkg::phase_t phase_step;
  logic [7:0]       current_color;
  logic             sign_positive;
  logic [8:0]       field_value;
  logic [3:0]       field_bits_seen;
  logic [PW-1:0]    pixels_emitted;
  logic             image_done;

  // byte being shifted
  logic             busy;
  logic [7:0]       byte_reg;
  logic [2:0]       bit_idx;

  // output register
  logic             out_valid;
  logic [7:0]       out_color;
  logic [PW-1:0]    out_count;
  logic             out_last;

  logic             adv;
  logic             bit_active;
  logic             finishing;
  logic             do_bit;
  logic             do_cmd;
  logic             cur_bit;

  logic [8:0]       fv_acc;
  logic [3:0]       fbs_acc;
  logic [3:0]       need;
  logic             field_full;
  logic [2:0]       v;
  logic             mode_sign;

  logic             bit_emit;
  logic [7:0]       color_step;
  logic [PW-1:0]    count_step;
  logic             sign_step;
  logic [8:0]       fv_step;
  logic [3:0]       fbs_step;
  logic             toggled;

  logic             emit_req;
  logic [7:0]       emit_color;
  logic [PW-1:0]    req_count;
  logic [PW-1:0]    pe_base;
  logic [PW-1:0]    total_eff;
  logic [PW-1:0]    remaining;
  logic [PW-1:0]    clamped;
  logic [PW-1:0]    pe_new;
  logic             emit_last;

  assign adv        = !out_valid || runs.ready;
  assign bit_active = busy && !image_done;
  assign finishing  = !busy || image_done || (bit_idx == 3'd7);
  assign pop        = adv && head.valid && finishing &&
                      (head.kind == pbid_pkg::K_BYTE || !bit_active);
  assign do_bit     = adv && bit_active;
  assign do_cmd     = pop && (head.kind != pbid_pkg::K_BYTE);
  assign cur_bit    = byte_reg[bit_idx];
  assign mode_sign  = (cfg.mode == pbid_pkg::MODE_SIGN);

  always_comb begin
    fv_acc  = field_value | ({8'd0, cur_bit} << field_bits_seen);
    fbs_acc = field_bits_seen + 4'd1;
    case (phase)
      pbid_pkg::PH_DELTA:   need = 4'd3;
      pbid_pkg::PH_RUN:     need = 4'd8;
      pbid_pkg::PH_LITERAL: need = cfg.palette_bits;
      default:              need = 4'd0;
    endcase
    field_full = (fbs_acc >= need);
    v          = fv_acc[2:0];
  end

  // next parse phase for one bit
  always_comb begin
    phase_step = phase;
    unique case (phase)
      pbid_pkg::PH_IDLE: begin
        phase_step = cur_bit ? pbid_pkg::PH_ONE : pbid_pkg::PH_IDLE;
      end
      pbid_pkg::PH_ONE: begin
        if (cur_bit) begin
          phase_step = mode_sign ? pbid_pkg::PH_SIGN : pbid_pkg::PH_DELTA;
        end else if (cfg.palette_bits == 4'd0) begin
          phase_step = pbid_pkg::PH_IDLE;
        end else begin
          phase_step = pbid_pkg::PH_LITERAL;
        end
      end
      pbid_pkg::PH_SIGN: begin
        phase_step = pbid_pkg::PH_IDLE;
      end
      pbid_pkg::PH_LITERAL, pbid_pkg::PH_RUN: begin
        if (field_full) begin
          phase_step = pbid_pkg::PH_IDLE;
        end
      end
      pbid_pkg::PH_DELTA: begin
        if (field_full) begin
          phase_step = (cfg.mode == pbid_pkg::MODE_RUNS && v == 3'd4) ?
                       pbid_pkg::PH_RUN : pbid_pkg::PH_IDLE;
        end
      end
      default: phase_step = pbid_pkg::PH_IDLE;
    endcase
  end

  // datapath effects of one bit
  always_comb begin
    bit_emit   = 1'b0;
    color_step = current_color;
    count_step = PW'(1);
    sign_step  = sign_positive;
    fv_step    = field_value;
    fbs_step   = field_bits_seen;
    toggled    = sign_positive ^ cur_bit;
    unique case (phase)
      pbid_pkg::PH_IDLE: begin
        bit_emit = !cur_bit;
      end
      pbid_pkg::PH_ONE: begin
        if (!cur_bit && cfg.palette_bits == 4'd0) begin
          color_step = 8'd0;
          if (mode_sign) begin
            sign_step = 1'b1;
          end
          bit_emit = 1'b1;
        end else begin
          fv_step  = '0;
          fbs_step = '0;
        end
      end
      pbid_pkg::PH_SIGN: begin
        sign_step  = toggled;
        color_step = current_color + (toggled ? 8'd255 : 8'd1);
        bit_emit   = 1'b1;
      end
      pbid_pkg::PH_LITERAL: begin
        fv_step  = fv_acc;
        fbs_step = fbs_acc;
        if (field_full) begin
          color_step = fv_acc[7:0];
          if (mode_sign) begin
            sign_step = 1'b1;
          end
          bit_emit = 1'b1;
        end
      end
      pbid_pkg::PH_RUN: begin
        fv_step  = fv_acc;
        fbs_step = fbs_acc;
        if (field_full) begin
          count_step = PW'({1'b0, fv_acc[7:0] - 8'd1} + 9'd1);
          bit_emit   = 1'b1;
        end
      end
      pbid_pkg::PH_DELTA: begin
        fv_step  = fv_acc;
        fbs_step = fbs_acc;
        if (field_full) begin
          if (cfg.mode == pbid_pkg::MODE_RUNS) begin
            if (v == 3'd4) begin
              fv_step  = '0;
              fbs_step = '0;
            end else begin
              color_step = current_color + {5'd0, v} + 8'd252;
              bit_emit   = 1'b1;
            end
          end else begin
            color_step = current_color + pbid_pkg::delta_of(v);
            bit_emit   = 1'b1;
          end
        end
      end
      default: bit_emit = 1'b0;
    endcase
  end

  // run clamping against the image total
  always_comb begin
    total_eff  = (cfg.total_pixels == '0) ? PW'(1) : cfg.total_pixels;
    emit_req   = do_cmd || (do_bit && bit_emit);
    emit_color = do_cmd ? cfg.fill_color : color_step;
    if (do_cmd) begin
      req_count = (head.kind == pbid_pkg::K_FILL) ? total_eff : PW'(1);
    end else begin
      req_count = count_step;
    end
    pe_base   = do_cmd ? '0 : pixels_emitted;
    remaining = (total_eff > pe_base) ? (total_eff - pe_base) : '0;
    clamped   = (req_count > remaining) ? remaining : req_count;
    if (clamped == '0) begin
      clamped = PW'(1);
    end
    pe_new    = pe_base + clamped;
    emit_last = (pe_new >= total_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      busy            <= 1'b0;
      phase           <= pbid_pkg::PH_IDLE;
      current_color   <= 8'd0;
      sign_positive   <= 1'b1;
      field_value     <= '0;
      field_bits_seen <= '0;
      pixels_emitted  <= '0;
      image_done      <= 1'b1;
    end else if (adv) begin
      out_valid <= emit_req;
      if (do_cmd) begin
        current_color   <= cfg.fill_color;
        sign_positive   <= 1'b1;
        phase           <= pbid_pkg::PH_IDLE;
        field_value     <= '0;
        field_bits_seen <= '0;
        pixels_emitted  <= pe_new;
        image_done      <= emit_last;
      end else if (do_bit) begin
        current_color   <= color_step;
        sign_positive   <= sign_step;
        field_value     <= fv_step;
        field_bits_seen <= fbs_step;
        if (emit_req) begin
          pixels_emitted <= pe_new;
        end
        if (emit_req && emit_last) begin
          phase      <= pbid_pkg::PH_IDLE;
          image_done <= 1'b1;
        end else begin
          phase <= phase_step;
        end
      end
      if (busy && finishing) begin
        busy <= 1'b0;
      end
      if (pop && head.kind == pbid_pkg::K_BYTE) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (busy && !finishing) begin
        bit_idx <= bit_idx + 3'd1;
      end
      if (pop && head.kind == pbid_pkg::K_BYTE) begin
        byte_reg <= head.data;
        bit_idx  <= 3'd0;
      end
      if (emit_req) begin
        out_color <= emit_color;
        out_count <= clamped;
        out_last  <= emit_last;
      end
    end
  end

  assign runs.valid        = out_valid;
  assign runs.pixel_color  = out_color;
  assign runs.repeat_count = out_count;
  assign runs.last         = out_last;

endmodule
